// ----- hw/rtl/cct_pkg.sv -----
// Shared types and constants for the cylindrical coordinate transform core.
// No dependencies; used by the core, its CORDIC stage and its checker.
`default_nettype none

package cct_pkg;

  // Command codes
  localparam logic CMD_TO_CYL  = 1'b0;  // global Cartesian -> cylindrical
  localparam logic CMD_TO_CART = 1'b1;  // cylindrical -> global Cartesian

  // Configuration register indexes
  localparam logic [1:0] REG_ROW0 = 2'd0;
  localparam logic [1:0] REG_ROW1 = 2'd1;
  localparam logic [1:0] REG_ROW2 = 2'd2;

  localparam int CFG_W      = 54;
  localparam int GUARD_BITS = 8;
  localparam int ATAN_N     = 40;

  // 1/K of the CORDIC in Q30
  localparam logic signed [30:0] KINV_S = 31'sd652032874;

  // atan(2^-i) as binary angle, full turn = 2^32
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0
  };

  // Control that travels with each item down the pipe
  typedef struct packed {
    logic valid;
    logic cmd;
    logic zero;   // radial part was zero (to-cylindrical only)
  } cct_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cct_cordic_stage.sv -----
// One registered CORDIC micro-rotation (vectoring or rotation per item cmd).
// Depends on cct_pkg.
`default_nettype none

module cct_cordic_stage import cct_pkg::*; #(
  parameter int          XW    = 46,
  parameter int          ZW    = 34,
  parameter int          LW    = 36,
  parameter int          SHIFT = 0,
  parameter logic [31:0] ATAN  = 32'd0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cct_ctl_t             ctl_in,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic signed [LW-1:0] lane_in,
  output cct_ctl_t             ctl_out,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic signed [LW-1:0] lane_out
);

  logic                 up;
  logic signed [XW-1:0] xs, ys;

  // vectoring drives y to zero, rotation drives z to zero
  assign up = (ctl_in.cmd == CMD_TO_CYL) ? !y_in[XW-1] : z_in[ZW-1];
  assign xs = y_in >>> SHIFT;
  assign ys = x_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    lane_out <= lane_in;
    if (up) begin
      x_out <= x_in + xs;
      y_out <= y_in - ys;
      z_out <= z_in + ZW'(ATAN);
    end else begin
      x_out <= x_in - xs;
      y_out <= y_in + ys;
      z_out <= z_in - ZW'(ATAN);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cylindrical_coordinate_transform_core.sv -----
// Top level of the cylindrical coordinate transform: matrix rotation, CORDIC
// pipeline, gain correction and saturation. Depends on cct_pkg, cct_cordic_stage.
//
//  channel   handshake          payload
//  --------  -----------------  ---------------------------------------------
//  input     start / busy       cmd, coord_a, coord_b, coord_c
//  result    done (1 cycle)     res_a, res_b, res_c, overflow
//  config    cfg_wr             cfg_addr, cfg_wdata (matrix rows 0..2)
//
// One item per cycle while busy is low; each result passes, in order, the
// stage-1 product registers, the CORDIC set-up register, one micro-rotation
// register per stage of the unrolled CORDIC, the K1 gain product and K2 radius
// finish / inverse rotation product registers, and the output register.
// rst is synchronous: it clears the valid bits and loads the identity matrix;
// busy is registered from rst, so it rises and falls in the cycle after rst does.
// The receiver cannot stall, so the pipe never holds; items simply advance.
`default_nettype none

module cylindrical_coordinate_transform_core import cct_pkg::*; #(
  parameter int COORD_WIDTH    = 32,
  parameter int COEF_FRAC_BITS = 16,
  parameter int CORDIC_STAGES  = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic signed [COORD_WIDTH-1:0] coord_a,
  input  logic signed [COORD_WIDTH-1:0] coord_b,
  input  logic signed [COORD_WIDTH-1:0] coord_c,
  input  logic                          cfg_wr,
  input  logic [1:0]                    cfg_addr,
  input  logic [CFG_W-1:0]              cfg_wdata,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] res_a,
  output logic signed [COORD_WIDTH-1:0] res_b,
  output logic signed [COORD_WIDTH-1:0] res_c,
  output logic                          overflow
);

  // widths
  localparam int CW   = COEF_FRAC_BITS + 2;        // coefficient
  localparam int PW   = COORD_WIDTH + CW;          // global * coef
  localparam int SW   = PW + 2;                    // sum of three
  localparam int LW   = SW - COEF_FRAC_BITS;       // local coordinate
  localparam int XW   = LW + GUARD_BITS + 2;       // CORDIC x/y
  localparam int ZW   = 34;                        // CORDIC angle
  localparam int AKW  = COORD_WIDTH + 31;          // radius * 1/K
  localparam int LVW  = XW - GUARD_BITS;           // local after CORDIC
  localparam int P2W  = LVW + CW;
  localparam int S2W  = P2W + 2;
  localparam int XHW  = XW - 21;                   // high part of split x
  localparam int PHW  = XHW + 31;
  localparam int PLW  = 53;
  localparam int RW   = XW + 33;
  localparam int SATW = COORD_WIDTH + 48;
  localparam int NST  = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
  localparam int LATENCY = NST + 5;
  localparam int HALF_F  = 2 ** (COEF_FRAC_BITS - 1);
  localparam int EXTW    = CFG_W + 3 * CW;

  localparam logic [CFG_W-1:0] ROW0_RST = CFG_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic [CFG_W-1:0] ROW1_RST = CFG_W'(64'd1 << (COEF_FRAC_BITS + CW));
  localparam logic [CFG_W-1:0] ROW2_RST = CFG_W'(64'd1 << (COEF_FRAC_BITS + 2 * CW));

  // coefficient j of a row; bits past the register read as zero
  function automatic logic signed [CW-1:0] coef_of(input logic [CFG_W-1:0] row,
                                                   input int j);
    logic [EXTW-1:0] ext;
    ext = EXTW'(row) >> (j * CW);
    return ext[CW-1:0];
  endfunction

  // clamp to the coordinate range; MSB of the result is the overflow flag
  function automatic logic [COORD_WIDTH:0] sat_c(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi, lo;
    hi = {{(SATW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (v > hi)      return {1'b1, hi[COORD_WIDTH-1:0]};
    else if (v < lo) return {1'b1, lo[COORD_WIDTH-1:0]};
    else             return {1'b0, v[COORD_WIDTH-1:0]};
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_W-1:0]     row [3];
  logic signed [CW-1:0] m [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0] <= ROW0_RST;
      row[1] <= ROW1_RST;
      row[2] <= ROW2_RST;
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_ROW0: row[0] <= cfg_wdata;
        REG_ROW1: row[1] <= cfg_wdata;
        REG_ROW2: row[2] <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = coef_of(row[i], j);
      end
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // angle input as a 32-bit binary angle
  logic [31:0] ua_in;
  generate
    if (COORD_WIDTH >= 32) begin : g_ang_in_wide
      assign ua_in = coord_b[31:0];
    end else begin : g_ang_in_narrow
      assign ua_in = {coord_b, {(32-COORD_WIDTH){1'b0}}};
    end
  endgenerate

  // ---------------- stage 1: products ----------------
  cct_ctl_t                      s1_ctl;
  logic signed [PW-1:0]          s1_p [3][3];
  logic signed [AKW-1:0]         s1_ak;
  logic [31:0]                   s1_ua;
  logic signed [COORD_WIDTH-1:0] s1_c;
  logic signed [COORD_WIDTH-1:0] g_in [3];

  assign g_in[0] = coord_a;
  assign g_in[1] = coord_b;
  assign g_in[2] = coord_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= start && !busy;
      s1_ctl.cmd   <= cmd;
      s1_ctl.zero  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_p[i][j] <= g_in[j] * m[i][j];
      end
    end
    s1_ak <= coord_a * KINV_S;
    s1_ua <= ua_in;
    s1_c  <= coord_c;
  end

  // ---------------- stage 2: CORDIC set-up ----------------
  logic signed [SW-1:0] s2_sum [3];
  logic signed [LW-1:0] loc [3];
  logic signed [XW-1:0] x0v, y0v, xk;
  logic signed [31:0]   t_in, t_fold;
  logic                 far;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_sum[i] = SW'(s1_p[i][0]) + SW'(s1_p[i][1]) + SW'(s1_p[i][2]) + SW'(HALF_F);
      loc[i]    = LW'(s2_sum[i] >>> COEF_FRAC_BITS);
    end
    x0v    = XW'(loc[0]) <<< GUARD_BITS;
    y0v    = XW'(loc[1]) <<< GUARD_BITS;
    xk     = XW'((s1_ak + AKW'(2 ** 21)) >>> 22);
    t_in   = $signed(s1_ua);
    t_fold = $signed(s1_ua + 32'h8000_0000);
    far    = (t_in > 32'sd1073741824) || (t_in < -32'sd1073741824);
  end

  cct_ctl_t             c_ctl  [NST+1];
  logic signed [XW-1:0] c_x    [NST+1];
  logic signed [XW-1:0] c_y    [NST+1];
  logic signed [ZW-1:0] c_z    [NST+1];
  logic signed [LW-1:0] c_lane [NST+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl[0] <= '0;
    end else begin
      c_ctl[0].valid <= s1_ctl.valid;
      c_ctl[0].cmd   <= s1_ctl.cmd;
      c_ctl[0].zero  <= (loc[0] == '0) && (loc[1] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctl.cmd == CMD_TO_CYL) begin
      // fold the left half-plane onto the right, angle starts at pi
      if (x0v[XW-1]) begin
        c_x[0] <= -x0v;
        c_y[0] <= -y0v;
        c_z[0] <= ZW'(33'h0_8000_0000);
      end else begin
        c_x[0] <= x0v;
        c_y[0] <= y0v;
        c_z[0] <= '0;
      end
      c_lane[0] <= loc[2];
    end else begin
      // angles beyond +-pi/2 rotate by pi first
      c_x[0]    <= far ? -xk : xk;
      c_y[0]    <= '0;
      c_z[0]    <= far ? ZW'(t_fold) : ZW'(t_in);
      c_lane[0] <= LW'(s1_c);
    end
  end

  // ---------------- CORDIC stages ----------------
  generate
    for (genvar k = 0; k < NST; k++) begin : g_cordic
      cct_cordic_stage #(
        .XW(XW), .ZW(ZW), .LW(LW), .SHIFT(k), .ATAN(ATAN_TAB[k])
      ) u_stage (
        .clk(clk), .rst(rst),
        .ctl_in(c_ctl[k]), .x_in(c_x[k]), .y_in(c_y[k]), .z_in(c_z[k]),
        .lane_in(c_lane[k]),
        .ctl_out(c_ctl[k+1]), .x_out(c_x[k+1]), .y_out(c_y[k+1]), .z_out(c_z[k+1]),
        .lane_out(c_lane[k+1])
      );
    end
  endgenerate

  // ---------------- K1: gain products / guard rounding ----------------
  cct_ctl_t              k1_ctl;
  logic signed [PHW-1:0] k1_ph;
  logic signed [PLW-1:0] k1_pl;
  logic signed [LVW-1:0] k1_lv [3];
  logic [31:0]           k1_ang;
  logic signed [LW-1:0]  k1_lane;
  logic signed [XHW-1:0] xh;

  assign xh = c_x[NST][XW-1:21];

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_ctl <= '0;
    end else begin
      k1_ctl <= c_ctl[NST];
    end
  end

  always_ff @(posedge clk) begin
    k1_ph    <= xh * KINV_S;
    k1_pl    <= $signed({1'b0, c_x[NST][20:0]}) * KINV_S;
    k1_lv[0] <= LVW'((c_x[NST] + XW'(128)) >>> GUARD_BITS);
    k1_lv[1] <= LVW'((c_y[NST] + XW'(128)) >>> GUARD_BITS);
    k1_lv[2] <= LVW'(c_lane[NST]);
    k1_ang   <= c_z[NST][31:0];
    k1_lane  <= c_lane[NST];
  end

  // ---------------- K2: radius finish / inverse rotation products ----------
  logic signed [RW-1:0]          rsum, r1, rad;
  logic [COORD_WIDTH:0]          rad_s, hgt_s;
  logic signed [COORD_WIDTH-1:0] ang_res;

  generate
    if (COORD_WIDTH >= 32) begin : g_ang_out_wide
      assign ang_res = COORD_WIDTH'($signed(k1_ang));
    end else begin : g_ang_out_narrow
      assign ang_res = k1_ang[31 -: COORD_WIDTH];
    end
  endgenerate

  always_comb begin
    rsum  = (RW'(k1_ph) <<< 21) + RW'(k1_pl) + RW'(2 ** 29);
    r1    = rsum >>> 30;
    rad   = (r1 + RW'(128)) >>> GUARD_BITS;
    rad_s = sat_c(SATW'(rad));
    hgt_s = sat_c(SATW'(k1_lane));
  end

  cct_ctl_t                      k2_ctl;
  logic signed [COORD_WIDTH-1:0] k2_a, k2_b, k2_c;
  logic                          k2_ov;
  logic signed [P2W-1:0]         k2_q [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      k2_ctl <= '0;
    end else begin
      k2_ctl <= k1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    k2_a  <= rad_s[COORD_WIDTH-1:0];
    k2_b  <= k1_ctl.zero ? '0 : ang_res;
    k2_c  <= hgt_s[COORD_WIDTH-1:0];
    k2_ov <= rad_s[COORD_WIDTH] | hgt_s[COORD_WIDTH];
    // global_i uses column i of M (transpose)
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        k2_q[i][j] <= k1_lv[j] * m[j][i];
      end
    end
  end

  // ---------------- output ----------------
  logic signed [S2W-1:0] gsum [3];
  logic [COORD_WIDTH:0]  gsat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gsum[i] = S2W'(k2_q[i][0]) + S2W'(k2_q[i][1]) + S2W'(k2_q[i][2]) + S2W'(HALF_F);
      gsat[i] = sat_c(SATW'(gsum[i] >>> COEF_FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= k2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (k2_ctl.cmd == CMD_TO_CYL) begin
      res_a    <= k2_a;
      res_b    <= k2_b;
      res_c    <= k2_c;
      overflow <= k2_ov;
    end else begin
      res_a    <= gsat[0][COORD_WIDTH-1:0];
      res_b    <= gsat[1][COORD_WIDTH-1:0];
      res_c    <= gsat[2][COORD_WIDTH-1:0];
      overflow <= gsat[0][COORD_WIDTH] | gsat[1][COORD_WIDTH] | gsat[2][COORD_WIDTH];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cct_chk.sv -----
// Port-level checker for the cylindrical coordinate transform core, with bind.
// Depends on cct_pkg and on the core's ports.
`default_nettype none

module cct_chk import cct_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int LATENCY     = 29
) (
  input wire                   clk,
  input wire                   rst,
  input wire                   start,
  input wire                   busy,
  input wire                   cmd,
  input wire                   done,
  input wire [COORD_WIDTH-1:0] res_a
);

  // every accepted item yields its result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("item accepted but no result after pipeline latency");

  // no result without an item accepted the latency before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  // busy only around reset
  a_busy_reset: assert property (@(posedge clk)
    (!rst && !$past(rst)) |-> !busy)
    else $error("busy outside reset");

  // a radius is never negative
  a_radius_sign: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && (cmd == CMD_TO_CYL), LATENCY))
      |-> !res_a[COORD_WIDTH-1])
    else $error("negative radius");

endmodule

bind cylindrical_coordinate_transform_core cct_chk #(
  .COORD_WIDTH(COORD_WIDTH),
  .LATENCY(LATENCY)
) u_cct_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
  .done(done), .res_a(res_a)
);

`default_nettype wire
